// ----- design/pidaw_pkg.sv -----
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types and constants of the anti-windup PID controller.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int VALUE_WIDTH    = 32;
  localparam int GAIN_WIDTH     = 32;
  localparam int BAND_WIDTH     = 31;
  localparam int INTEG_WIDTH    = 48;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 32;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_PROP  = 3'd1,
    REG_GAIN_INTEG = 3'd2,
    REG_GAIN_DERIV = 3'd3,
    REG_DRIVE_MAX  = 3'd4,
    REG_DRIVE_MIN  = 3'd5,
    REG_INTEG_BAND = 3'd6
  } reg_idx_e;

  localparam logic signed [VALUE_WIDTH-1:0] SETPOINT_RST   = 32'sd1572864;
  localparam logic signed [GAIN_WIDTH-1:0]  GAIN_PROP_RST  = 32'sd105696;
  localparam logic signed [GAIN_WIDTH-1:0]  GAIN_INTEG_RST = 32'sd31877;
  localparam logic signed [GAIN_WIDTH-1:0]  GAIN_DERIV_RST = 32'sd33554;
  localparam logic signed [VALUE_WIDTH-1:0] DRIVE_MAX_RST  = 32'sd65536;
  localparam logic signed [VALUE_WIDTH-1:0] DRIVE_MIN_RST  = 32'sd32768;
  localparam logic [BAND_WIDTH-1:0]         INTEG_BAND_RST = 31'd6553600;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] setpoint;
    logic signed [GAIN_WIDTH-1:0]  gain_prop;
    logic signed [GAIN_WIDTH-1:0]  gain_integ;
    logic signed [GAIN_WIDTH-1:0]  gain_deriv;
    logic signed [VALUE_WIDTH-1:0] drive_max;
    logic signed [VALUE_WIDTH-1:0] drive_min;
    logic [BAND_WIDTH-1:0]         integ_band;
  } cfg_t;

endpackage

// ----- design/pid_antiwindup_controller_unit.sv -----
// ----------------------------------------------------------------------------
// pid_antiwindup_controller_unit
// Positional PID controller with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid_i / in_ready_o, one measured_value_i per item
//   output channel : out_valid_o / out_ready_i, one drive_value_o per item
//   config channel : cfg_valid_i / cfg_ready_o with cfg_index_i, cfg_data_i;
//                    always ready, index 0..6 selects the register, others
//                    are dropped; write only while no item is in flight
// Path: an accepted item lands in the input register; when the output register is
//   free, its drive value is loaded into the output register and out_valid_o
//   rises.
// Throughput: one item per cycle while the receiver takes results; the rate
//   is set by the update of the integral, last error and last drive, which
//   each item reads and writes as it advances.
// Stall: while a result waits, one more item is taken into the input
//   register; then in_ready_o drops until the result is taken.
// Reset: registers take their power-on values, integral and history clear,
//   both pipeline registers empty.
// ----------------------------------------------------------------------------
module pid_antiwindup_controller_unit #(
  parameter int GainFracBits = pidaw_pkg::GAIN_FRAC_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [pidaw_pkg::VALUE_WIDTH-1:0] measured_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [pidaw_pkg::VALUE_WIDTH-1:0] drive_value_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [pidaw_pkg::CFG_IDX_WIDTH-1:0]      cfg_index_i,
  input  logic [pidaw_pkg::CFG_DATA_WIDTH-1:0]     cfg_data_i
);
  import pidaw_pkg::*;

  cfg_t cfg;

  logic                          in_valid_q;
  logic signed [VALUE_WIDTH-1:0] meas_q;
  logic                          out_valid_q;
  logic signed [VALUE_WIDTH-1:0] drive_q;
  logic signed [VALUE_WIDTH-1:0] drive_d;
  logic                          advance;
  logic                          in_accept;

  assign cfg_ready_o = 1'b1;

  pidaw_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // item moves from input register to result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  pidaw_core #(
    .GainFracBits (GainFracBits)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .cfg_i   (cfg),
    .meas_i  (meas_q),
    .drive_o (drive_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) meas_q  <= measured_value_i;
    if (advance)   drive_q <= drive_d;
  end

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;

  a_ready_low_only_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_o && !out_ready_i)
  ) else $error("input stalled without a waiting result");

  a_advance_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o
  ) else $error("computed item did not reach the result register");

  a_held_item_kept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(meas_q))
  ) else $error("stalled item lost from the input register");

endmodule

// ----- design/pidaw_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pidaw_cfg_regs
// Configuration register file: setpoint, gains, output clamps and band.
// ----------------------------------------------------------------------------
module pidaw_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [pidaw_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [pidaw_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i,
  output pidaw_pkg::cfg_t                       cfg_o
);
  import pidaw_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SETPOINT:   cfg_d.setpoint   = $signed(cfg_data_i);
        REG_GAIN_PROP:  cfg_d.gain_prop  = $signed(cfg_data_i);
        REG_GAIN_INTEG: cfg_d.gain_integ = $signed(cfg_data_i);
        REG_GAIN_DERIV: cfg_d.gain_deriv = $signed(cfg_data_i);
        REG_DRIVE_MAX:  cfg_d.drive_max  = $signed(cfg_data_i);
        REG_DRIVE_MIN:  cfg_d.drive_min  = $signed(cfg_data_i);
        REG_INTEG_BAND: cfg_d.integ_band = cfg_data_i[BAND_WIDTH-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint   <= SETPOINT_RST;
      cfg_q.gain_prop  <= GAIN_PROP_RST;
      cfg_q.gain_integ <= GAIN_INTEG_RST;
      cfg_q.gain_deriv <= GAIN_DERIV_RST;
      cfg_q.drive_max  <= DRIVE_MAX_RST;
      cfg_q.drive_min  <= DRIVE_MIN_RST;
      cfg_q.integ_band <= INTEG_BAND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/pidaw_core.sv -----
// ----------------------------------------------------------------------------
// pidaw_core
// Controller state and one-pass PID arithmetic with conditional integration.
// ----------------------------------------------------------------------------
module pidaw_core #(
  parameter int GainFracBits = pidaw_pkg::GAIN_FRAC_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    step_i,
  input  pidaw_pkg::cfg_t                         cfg_i,
  input  logic signed [pidaw_pkg::VALUE_WIDTH-1:0] meas_i,
  output logic signed [pidaw_pkg::VALUE_WIDTH-1:0] drive_o
);
  import pidaw_pkg::*;

  localparam int SumW = 82;
  localparam logic signed [VALUE_WIDTH-1:0] ErrMax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] ErrMin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [INTEG_WIDTH-1:0] IntMax = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
  localparam logic signed [INTEG_WIDTH-1:0] IntMin = {1'b1, {(INTEG_WIDTH-1){1'b0}}};

  logic signed [INTEG_WIDTH-1:0] integ_q, integ_d;
  logic signed [VALUE_WIDTH-1:0] prev_err_q;
  logic signed [VALUE_WIDTH-1:0] prev_drive_q;

  logic signed [VALUE_WIDTH:0]   diff;
  logic signed [VALUE_WIDTH-1:0] err;
  logic [VALUE_WIDTH-1:0]        mag;
  logic signed [INTEG_WIDTH:0]   isum;
  logic signed [INTEG_WIDTH-1:0] isat;

  logic signed [63:0]            p_prod;
  logic signed [63:0]            i_prod_hi;
  logic signed [48:0]            i_prod_lo;
  logic signed [79:0]            i_prod;
  logic signed [VALUE_WIDTH:0]   ediff;
  logic signed [64:0]            d_prod;
  logic signed [SumW-1:0]        sum;
  logic signed [SumW-1:0]        clamp_hi;
  logic signed [SumW-1:0]        clamped;

  // error, saturated to the value width
  assign diff = {cfg_i.setpoint[VALUE_WIDTH-1], cfg_i.setpoint}
              - {meas_i[VALUE_WIDTH-1], meas_i};
  assign err  = (diff[VALUE_WIDTH] != diff[VALUE_WIDTH-1])
              ? (diff[VALUE_WIDTH] ? ErrMin : ErrMax)
              : diff[VALUE_WIDTH-1:0];
  assign mag  = err[VALUE_WIDTH-1] ? (~err + 1'b1) : err;

  assign isum = {{(INTEG_WIDTH-VALUE_WIDTH+1){err[VALUE_WIDTH-1]}}, err}
              + {integ_q[INTEG_WIDTH-1], integ_q};
  assign isat = (isum[INTEG_WIDTH] != isum[INTEG_WIDTH-1])
              ? (isum[INTEG_WIDTH] ? IntMin : IntMax)
              : isum[INTEG_WIDTH-1:0];

  // at a clamp integrate only to back off; else integrate in band or clear
  always_comb begin
    integ_d = integ_q;
    if (prev_drive_q >= cfg_i.drive_max) begin
      if (err <= 0) integ_d = isat;
    end else if (prev_drive_q <= cfg_i.drive_min) begin
      if (err >= 0) integ_d = isat;
    end else if (mag <= {1'b0, cfg_i.integ_band}) begin
      integ_d = isat;
    end else begin
      integ_d = '0;
    end
  end

  assign p_prod    = cfg_i.gain_prop * err;
  // integral term as two partial products: signed upper word, unsigned low half
  assign i_prod_hi = cfg_i.gain_integ * $signed(integ_d[47:16]);
  assign i_prod_lo = cfg_i.gain_integ * $signed({1'b0, integ_d[15:0]});
  assign i_prod    = $signed({i_prod_hi, 16'b0}) + 80'(i_prod_lo);
  assign ediff     = {err[VALUE_WIDTH-1], err} - {prev_err_q[VALUE_WIDTH-1], prev_err_q};
  assign d_prod    = cfg_i.gain_deriv * ediff;

  // arithmetic shifts floor toward minus infinity
  assign sum = SumW'(p_prod >>> GainFracBits)
             + SumW'(i_prod >>> GainFracBits)
             + SumW'(d_prod >>> GainFracBits);

  // upper clamp first, then lower: inverted clamps give drive_min
  assign clamp_hi = (sum >= SumW'(cfg_i.drive_max)) ? SumW'(cfg_i.drive_max) : sum;
  assign clamped  = (clamp_hi <= SumW'(cfg_i.drive_min)) ? SumW'(cfg_i.drive_min)
                                                         : clamp_hi;
  assign drive_o  = clamped[VALUE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q      <= '0;
      prev_err_q   <= '0;
      prev_drive_q <= '0;
    end else if (step_i) begin
      integ_q      <= integ_d;
      prev_err_q   <= err;
      prev_drive_q <= drive_o;
    end
  end

endmodule
